>>> rtl/stp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants for the sectioned time parser
// Field widths, status and register codes, character codes, reset values.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int CHAR_W    = 8;
  localparam int DATA_W    = 40;
  localparam int SEC_W     = 16;
  localparam int BASE_W    = 9;
  localparam int EXP_W     = 3;
  localparam int CFG_IDX_W = 2;
  // a * b + c, one bit of headroom over the product
  localparam int MAC_W     = DATA_W + BASE_W + 1;

  localparam int MAX_SECTIONS_DEF = 4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BASE_W-1:0] DEC_BASE = 9'd10;

  localparam logic [EXP_W-1:0]  RST_EXPECTED = 3'd3;
  localparam logic [SEC_W-1:0]  RST_MAX_SEC  = 16'd59;
  localparam logic [BASE_W-1:0] RST_BASE     = 9'd60;
  localparam logic [DATA_W-1:0] RST_LIMIT    = 40'd86400;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_UNEXP_CHAR  = 3'd1,
    STATUS_TOO_MANY    = 3'd2,
    STATUS_SEC_LARGE   = 3'd3,
    STATUS_TOTAL_LARGE = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED = 2'd0,
    CFG_MAX_SEC  = 2'd1,
    CFG_BASE     = 2'd2,
    CFG_LIMIT    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_EXEC  = 3'd1,
    ST_FOLD  = 3'd2,
    ST_SCALE = 3'd3,
    ST_EMIT  = 3'd4
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
    logic              is_empty;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] total_value;
    status_t           status;
  } out_item_t;

  typedef struct packed {
    logic [EXP_W-1:0]  section_count;
    logic [SEC_W-1:0]  section_max;
    logic [BASE_W-1:0] section_base;
    logic [DATA_W-1:0] total_limit;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/stp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stp_cfg: configuration register bank
// Write-only registers, decoded by index, reset to their defaults.
// ----------------------------------------------------------------------------
module stp_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire stp_pkg::cfg_idx_t                  cfg_index,
  input  wire logic [stp_pkg::DATA_W-1:0]         cfg_data,
  output stp_pkg::cfg_t                           cfg
);
  import stp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.section_count <= RST_EXPECTED;
      cfg.section_max   <= RST_MAX_SEC;
      cfg.section_base  <= RST_BASE;
      cfg.total_limit   <= RST_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED: cfg.section_count <= cfg_data[EXP_W-1:0];
        CFG_MAX_SEC:  cfg.section_max   <= cfg_data[SEC_W-1:0];
        CFG_BASE:     cfg.section_base  <= cfg_data[BASE_W-1:0];
        CFG_LIMIT:    cfg.total_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/stp_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stp_mac: shared multiply-add unit
// raw = a * b + c, plus a copy saturated to the total width and its flag.
// ----------------------------------------------------------------------------
module stp_mac (
  input  wire logic [stp_pkg::DATA_W-1:0] a,
  input  wire logic [stp_pkg::BASE_W-1:0] b,
  input  wire logic [stp_pkg::SEC_W-1:0]  c,
  output logic [stp_pkg::MAC_W-1:0]       raw,
  output logic [stp_pkg::DATA_W-1:0]      sat,
  output logic                            over
);
  import stp_pkg::*;

  localparam int PROD_W = DATA_W + BASE_W;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(a) * PROD_W'(b);
  assign raw  = MAC_W'(prod) + MAC_W'(c);
  assign over = |raw[MAC_W-1:DATA_W];
  assign sat  = over ? {DATA_W{1'b1}} : raw[DATA_W-1:0];

endmodule
`default_nettype wire

>>> rtl/sectioned_time_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sectioned_time_parser_unit: colon separated time string parser
// Characters of a string such as hh:mm:ss enter one per transfer on the
// input channel (in_valid / in_stall / in_data). One result per string
// (total in the smallest unit plus a status code) leaves on the output
// channel (out_valid / out_stall / out_data) when is_last or is_empty is set.
// Flow: an ordinary character is accepted, then takes one pass through the
// shared multiply-add. A final character is accepted, the open section is
// folded in and each missing trailing section (0 to 3 at the default
// MAX_SECTIONS) is scaled by the base, one multiply-add per cycle, before
// the result is registered; a string already in error skips fold and scaling.
// The next character is taken once the block is back in idle. in_stall is
// high while a character is worked on. The result sits in an output register;
// while the receiver stalls it, the block holds the next final result back,
// but ordinary characters go on. Reset (rst, synchronous) restores the
// configuration defaults (3 sections, section max 59, base 60, limit 86400)
// and clears the parse state. The user writes configuration through cfg_we /
// cfg_index / cfg_data only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module sectioned_time_parser_unit #(
  parameter int MAX_SECTIONS = stp_pkg::MAX_SECTIONS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire stp_pkg::cfg_idx_t          cfg_index,
  input  wire logic [stp_pkg::DATA_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire stp_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output stp_pkg::out_item_t              out_data
);
  import stp_pkg::*;

  // section counter runs up to the effective count plus one
  localparam int SEEN_W = $clog2(MAX_SECTIONS + 2);
  localparam int CMP_W  = (SEEN_W > EXP_W) ? SEEN_W : EXP_W;

  cfg_t cfg;

  // sequencer and parse state
  state_t              state, state_next;
  in_item_t            item_q;
  logic [DATA_W-1:0]   running_total, running_total_next;
  logic [SEC_W-1:0]    current_section, current_section_next;
  logic [SEEN_W-1:0]   sections_seen, sections_seen_next;
  status_t             first_error, first_error_next;
  logic                total_overflow, total_overflow_next;
  logic                out_valid_next;
  out_item_t           out_data_next;

  // shared multiply-add operands and results
  logic [DATA_W-1:0]   mac_a;
  logic [BASE_W-1:0]   mac_b;
  logic [SEC_W-1:0]    mac_c;
  logic [MAC_W-1:0]    mac_raw;
  logic [DATA_W-1:0]   mac_sat;
  logic                mac_over;

  logic [CMP_W-1:0]    exp_ext, eff_full;
  logic [SEEN_W-1:0]   eff_expected;
  logic [SEEN_W-1:0]   seen_inc;
  logic                is_digit, is_colon;
  logic [3:0]          digit;
  logic                out_free;
  status_t             emit_status;

  stp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stp_mac u_mac (
    .a    (mac_a),
    .b    (mac_b),
    .c    (mac_c),
    .raw  (mac_raw),
    .sat  (mac_sat),
    .over (mac_over)
  );

  // expected count clamps to the build-time maximum
  assign exp_ext      = CMP_W'(cfg.section_count);
  assign eff_full     = (exp_ext > CMP_W'(MAX_SECTIONS)) ? CMP_W'(MAX_SECTIONS) : exp_ext;
  assign eff_expected = SEEN_W'(eff_full);
  assign seen_inc     = sections_seen + SEEN_W'(1);

  assign is_digit = (item_q.char_code >= CH_ZERO) && (item_q.char_code <= CH_NINE);
  assign is_colon = (item_q.char_code == CH_COLON);
  assign digit    = 4'(item_q.char_code - CH_ZERO);

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // operand select: digit step, scaling step, otherwise fold the open section
  always_comb begin
    mac_a = running_total;
    mac_b = cfg.section_base;
    mac_c = current_section;
    if (state == ST_EXEC && is_digit) begin
      mac_a = DATA_W'(current_section);
      mac_b = DEC_BASE;
      mac_c = SEC_W'(digit);
    end else if (state == ST_SCALE) begin
      mac_c = '0;
    end
  end

  // with no error held, saturation reports too-large whatever the base did after
  always_comb begin
    if (first_error != STATUS_OK) begin
      emit_status = first_error;
    end else if (total_overflow || (running_total > cfg.total_limit)) begin
      emit_status = STATUS_TOTAL_LARGE;
    end else begin
      emit_status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      running_total   <= '0;
      current_section <= '0;
      sections_seen   <= SEEN_W'(1);
      first_error     <= STATUS_OK;
      total_overflow  <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      running_total   <= running_total_next;
      current_section <= current_section_next;
      sections_seen   <= sections_seen_next;
      first_error     <= first_error_next;
      total_overflow  <= total_overflow_next;
      out_valid       <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item_q <= in_data;
    end
    out_data <= out_data_next;
  end

  always_comb begin
    state_next           = state;
    running_total_next   = running_total;
    current_section_next = current_section;
    sections_seen_next   = sections_seen;
    first_error_next     = first_error;
    total_overflow_next  = total_overflow;
    out_valid_next       = out_valid && out_stall;
    out_data_next        = out_data;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // errors are sticky: later characters are ignored
        if (!item_q.is_empty && first_error == STATUS_OK) begin
          if (is_digit) begin
            if (mac_raw > MAC_W'(cfg.section_max)) begin
              first_error_next = STATUS_SEC_LARGE;
            end else begin
              current_section_next = mac_raw[SEC_W-1:0];
            end
          end else if (is_colon) begin
            running_total_next   = mac_sat;
            total_overflow_next  = total_overflow || mac_over;
            current_section_next = '0;
            sections_seen_next   = seen_inc;
            if (seen_inc > eff_expected) begin
              first_error_next = STATUS_TOO_MANY;
            end
          end else begin
            first_error_next = STATUS_UNEXP_CHAR;
          end
        end
        if (item_q.is_empty || item_q.is_last) begin
          state_next = ST_FOLD;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_FOLD: begin
        if (first_error != STATUS_OK) begin
          state_next = ST_EMIT;
        end else begin
          running_total_next  = mac_sat;
          total_overflow_next = total_overflow || mac_over;
          state_next          = ST_SCALE;
        end
      end

      // one base multiply per missing trailing section
      ST_SCALE: begin
        if (sections_seen < eff_expected) begin
          running_total_next  = mac_sat;
          total_overflow_next = total_overflow || mac_over;
          sections_seen_next  = seen_inc;
        end else begin
          state_next = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_next            = 1'b1;
          out_data_next.status      = emit_status;
          out_data_next.total_value = (emit_status == STATUS_OK) ? running_total : '0;
          running_total_next        = '0;
          current_section_next      = '0;
          sections_seen_next        = SEEN_W'(1);
          first_error_next          = STATUS_OK;
          total_overflow_next       = 1'b0;
          state_next                = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> test/tb_sectioned_time_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sectioned_time_parser_unit: self-checking bench for the time parser
// Sends time strings one character per transfer: first a short directed
// script, then random strings under several register settings and idling
// patterns. Each result is checked against a typed value or the bench model.
// ----------------------------------------------------------------------------
module tb_sectioned_time_parser_unit;
  import stp_pkg::*;

  localparam logic [DATA_W-1:0] TOP40 = '1;
  localparam int LIMIT_CYCLES  = 800000;
  localparam int SETTLE_CYCLES = 16;   // room for a final char's fold and scaling
  localparam int PHASE_ITEMS   = 325;
  localparam int NUM_PHASES    = 6;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  cfg_idx_t          cfg_index = CFG_EXPECTED;
  logic [DATA_W-1:0] cfg_data  = '0;
  logic              in_valid  = 1'b0;
  in_item_t          in_data   = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  out_item_t         out_data;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sectioned_time_parser_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Parser model: register mirror and per-string parse state
  // ---------------------------------------------------------------------------
  logic [EXP_W-1:0]  m_sections;
  logic [SEC_W-1:0]  m_max_sec;
  logic [BASE_W-1:0] m_base;
  logic [DATA_W-1:0] m_limit;

  logic [DATA_W-1:0] acc_total;
  logic [16:0]       sec_val;
  int                sec_count;
  status_t           err_code;
  bit                sat_flag;

  out_item_t totals_due[$];   // expected results, oldest first
  int        fault_count  = 0;
  int        cycle_count  = 0;
  int        send_gap_pct = 0;
  int        stall_pct    = 0;
  int        phase_items  = 0;

  function automatic int eff_sections();
    return (m_sections > MAX_SECTIONS_DEF) ? MAX_SECTIONS_DEF : int'(m_sections);
  endfunction

  // total * base + add, saturating at 40 bits; saturation is remembered
  function automatic logic [DATA_W-1:0] mul_add(input logic [DATA_W-1:0] t,
                                                input logic [16:0] add,
                                                inout bit ovf);
    logic [63:0] v;
    v = 64'(t) * 64'(m_base) + 64'(add);
    if (v > 64'(TOP40)) begin
      ovf = 1'b1;
      v   = 64'(TOP40);
    end
    return v[DATA_W-1:0];
  endfunction

  task automatic clear_parse();
    acc_total = '0;
    sec_val   = '0;
    sec_count = 1;
    err_code  = STATUS_OK;
    sat_flag  = 1'b0;
  endtask

  // One accepted character; a result comes out on is_last or is_empty
  task automatic parse_char(input in_item_t it, output bit has_res, output out_item_t res);
    int unsigned       digit_sum;
    logic [DATA_W-1:0] tot;
    status_t           code;
    has_res = 1'b0;
    res     = '0;
    if (!it.is_empty && err_code == STATUS_OK) begin
      if (it.char_code >= CH_ZERO && it.char_code <= CH_NINE) begin
        digit_sum = 32'(sec_val) * 32'(DEC_BASE) + 32'(it.char_code - CH_ZERO);
        if (digit_sum > 32'(m_max_sec)) err_code = STATUS_SEC_LARGE;
        else sec_val = digit_sum[16:0];
      end else if (it.char_code == CH_COLON) begin
        acc_total = mul_add(acc_total, sec_val, sat_flag);
        sec_val   = '0;
        sec_count++;
        if (sec_count > eff_sections()) err_code = STATUS_TOO_MANY;
      end else begin
        err_code = STATUS_UNEXP_CHAR;
      end
    end
    if (it.is_empty || it.is_last) begin
      code = err_code;
      tot  = '0;
      if (code == STATUS_OK) begin
        tot = mul_add(acc_total, sec_val, sat_flag);
        // missing trailing sections scale by the base
        while (sec_count < eff_sections()) begin
          tot = mul_add(tot, '0, sat_flag);
          sec_count++;
        end
        if (sat_flag || tot > m_limit) code = STATUS_TOTAL_LARGE;
      end
      if (code != STATUS_OK) tot = '0;
      res.total_value = tot;
      res.status      = code;
      has_res         = 1'b1;
      clear_parse();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one transfer, then random idle cycles
  // ---------------------------------------------------------------------------
  task automatic transfer(input in_item_t it, input bit typed, input out_item_t typed_res);
    bit        has_res;
    out_item_t res;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    phase_items++;
    parse_char(it, has_res, res);
    // directed rows carry a hand-written result where it is obvious
    if (has_res) totals_due.push_back(typed ? typed_res : res);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Sender holds off until every result is out, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers, junk above the width of the three narrower ones
  task automatic program_regs(input logic [EXP_W-1:0] e, input logic [SEC_W-1:0] m,
                              input logic [BASE_W-1:0] b, input logic [DATA_W-1:0] l);
    logic [DATA_W-1:0] junk;
    junk = DATA_W'({$urandom, $urandom});
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXPECTED;
    cfg_data  <= {junk[DATA_W-1:EXP_W], e};
    @(posedge clk);
    cfg_index <= CFG_MAX_SEC;
    cfg_data  <= {junk[DATA_W-1:SEC_W], m};
    @(posedge clk);
    cfg_index <= CFG_BASE;
    cfg_data  <= {junk[DATA_W-1:BASE_W], b};
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data  <= l;
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_sections = e;
    m_max_sec  = m;
    m_base     = b;
    m_limit    = l;
  endtask

  // Mostly well-formed strings sized to the current setting, with some
  // oversize sections, extra colons, stray characters and early ends
  task automatic send_random_string();
    in_item_t    seq[$];
    in_item_t    it;
    int          nsec;
    int          pick;
    int unsigned val;
    int          lead;
    byte         digs[$];
    it = '0;
    if ($urandom_range(99) < 4) begin
      it.char_code = 8'($urandom_range(255));
      it.is_last   = 1'($urandom_range(1));
      it.is_empty  = 1'b1;
      transfer(it, 1'b0, '0);
      return;
    end
    nsec = $urandom_range((eff_sections() > 0) ? eff_sections() : 1, 1);
    if ($urandom_range(99) < 8) nsec++;
    for (int s = 0; s < nsec; s++) begin
      if (s > 0) begin
        it.char_code = CH_COLON;
        seq.push_back(it);
      end
      pick = $urandom_range(99);
      if (pick < 25) val = 32'(m_max_sec);
      else if (pick < 35) val = 0;
      else if (pick < 43) val = 32'(m_max_sec) + 1 + $urandom_range(9);
      else val = $urandom_range(32'(m_max_sec));
      if ($urandom_range(99) >= 8) begin
        lead = ($urandom_range(99) < 15) ? $urandom_range(2, 1) : 0;
        digs.delete();
        do begin
          digs.push_front(byte'(val % 10));
          val = val / 10;
        end while (val > 0);
        repeat (lead) digs.push_front(8'd0);
        foreach (digs[k]) begin
          it.char_code = CH_ZERO + 8'(digs[k]);
          seq.push_back(it);
        end
      end
    end
    if ($urandom_range(99) < 5) begin
      it.char_code = CH_COLON;
      seq.push_back(it);
    end
    if (seq.size() != 0 && $urandom_range(99) < 6)
      seq[$urandom_range(seq.size() - 1)].char_code = 8'($urandom_range(255));
    // end the string with an empty marker now and then
    if (seq.size() == 0 || $urandom_range(99) < 8) begin
      it.char_code = 8'($urandom_range(255));
      it.is_last   = 1'($urandom_range(1));
      it.is_empty  = 1'b1;
      seq.push_back(it);
    end else begin
      seq[seq.size() - 1].is_last = 1'b1;
    end
    foreach (seq[k]) transfer(seq[k], 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Directed script, run at the reset setting (3 sections, max 59, base 60,
  // limit 86400). Results are typed in only on string-ending rows.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } script_row_t;

  script_row_t script [22] = '{
    // empty string, all-ones character, is_last set too
    '{ {8'hFF, 1'b1, 1'b1}, 1'b1, '{40'd0, STATUS_OK} },
    // 23:59:59, one below the limit
    '{ {"2", 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {"3", 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {CH_COLON, 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {"5", 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {"9", 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {CH_COLON, 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {"5", 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {"9", 1'b1, 1'b0}, 1'b1, '{40'd86399, STATUS_OK} },
    // 24 hours exactly hits the limit
    '{ {"2", 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {"4", 1'b1, 1'b0}, 1'b1, '{40'd86400, STATUS_OK} },
    // 25 hours is over the limit
    '{ {"2", 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {"5", 1'b1, 1'b0}, 1'b1, '{40'd0, STATUS_TOTAL_LARGE} },
    // section of 60 exceeds the section maximum
    '{ {"6", 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {"0", 1'b1, 1'b0}, 1'b1, '{40'd0, STATUS_SEC_LARGE} },
    // NUL character, error sticks over the following digit
    '{ {8'h00, 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {"1", 1'b1, 1'b0}, 1'b1, '{40'd0, STATUS_UNEXP_CHAR} },
    // third colon opens a fourth section
    '{ {CH_COLON, 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {CH_COLON, 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {CH_COLON, 1'b1, 1'b0}, 1'b1, '{40'd0, STATUS_TOO_MANY} },
    // empty marker mid string ends it, its character is dropped
    '{ {"5", 1'b0, 1'b0}, 1'b0, '{40'd0, STATUS_OK} },
    '{ {"x", 1'b0, 1'b1}, 1'b1, '{40'd18000, STATUS_OK} }
  };

  // ---------------------------------------------------------------------------
  // Output side: random stall, result check against the oldest expectation
  // ---------------------------------------------------------------------------
  out_item_t head;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (totals_due.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected result: total %0d status %0d",
                   out_data.total_value, out_data.status);
        fault_count++;
      end else begin
        head = totals_due.pop_front();
        if (out_data.total_value !== head.total_value || out_data.status !== head.status) begin
          if (fault_count < 10)
            $display("result mismatch: expected total %0d status %0d, got total %0d status %0d",
                     head.total_value, head.status, out_data.total_value, out_data.status);
          fault_count++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    m_sections = RST_EXPECTED;
    m_max_sec  = RST_MAX_SEC;
    m_base     = RST_BASE;
    m_limit    = RST_LIMIT;
    clear_parse();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // idle pattern: sender light / receiver heavy, then swapped, then none
      case (ph / 2)
        0: begin
          send_gap_pct = 16;
          stall_pct    = 82;
        end
        1: begin
          send_gap_pct = 82;
          stall_pct    = 16;
        end
        default: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
      endcase
      case (ph)
        0: ;  // reset setting
        // widest fields: saturation of the total
        1: program_regs(3'd4, 16'hFFFF, 9'h1FF, TOP40);
        // all zero: every colon is an error, base zero
        2: program_regs(3'd0, 16'd0, 9'd0, 40'd0);
        // single section, unit base
        3: program_regs(3'd1, 16'd9, 9'd1, 40'd5);
        // section count above the maximum acts as the maximum
        4: program_regs(3'd7, 16'd999, 9'd256, {8'($urandom_range(255)), $urandom});
        default: program_regs(3'd2, 16'($urandom_range(65535)), 9'd2, 40'd1000);
      endcase
      phase_items = 0;
      if (ph == 0) begin
        foreach (script[i]) transfer(script[i].item, script[i].typed, script[i].res);
        drain();
      end
      while (phase_items < PHASE_ITEMS / 2) send_random_string();
      drain();  // hold the sender until the block has emptied
      while (phase_items < PHASE_ITEMS) send_random_string();
      drain();
    end

    if (fault_count == 0 && totals_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
